@@ sv/frc_pkg.sv @@
// ----------------------------------------------------------------------------
// frc_pkg
// Shared types and constants of the frame capture ring: the command beat,
// the result beat and the action codes.
// ----------------------------------------------------------------------------
package frc_pkg;

  localparam int SEQ_W  = 48;
  localparam int TIME_W = 32;
  localparam int LEN_W  = 16;
  localparam int CNT_W  = 32;
  localparam int TOT_W  = 48;
  localparam int OFF_W  = 7;
  localparam int BYTE_W = 8;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  localparam logic ACT_CAPTURE = 1'b0;
  localparam logic ACT_READ    = 1'b1;

  typedef struct packed {
    logic              action;
    logic              direction;
    logic [BYTE_W-1:0] data_byte;
    logic              frame_last;
    logic [TIME_W-1:0] timestamp;
    logic [SEQ_W-1:0]  read_seq;
    logic [OFF_W-1:0]  read_offset;
  } frc_in_t;

  typedef struct packed {
    logic              frame_found;
    logic [SEQ_W-1:0]  frame_seq;
    logic [BYTE_W-1:0] frame_byte;
    logic [LEN_W-1:0]  frame_length;
    logic [7:0]        frame_captured;
    logic              frame_direction;
    logic [TIME_W-1:0] frame_time;
    logic [CNT_W-1:0]  receive_frames;
    logic [TOT_W-1:0]  receive_bytes;
    logic [CNT_W-1:0]  transmit_frames;
    logic [TOT_W-1:0]  transmit_bytes;
    logic [SEQ_W-1:0]  next_sequence;
  } frc_out_t;

endpackage

@@ sv/frame_capture_ring_core.sv @@
// ----------------------------------------------------------------------------
// frame_capture_ring_core
// Capture ring for network frames: bytes go into a slot RAM, headers into a
// header RAM, and reads return one byte plus the header of a held frame.
// ----------------------------------------------------------------------------
// Capture beat: result strobes the next cycle, busy stays low.
// Read beat: busy through the clamp, distance, slot, RAM read and data
//   states; result strobes as busy drops, when the data state ends.
// done_o is a one-cycle strobe; the receiver cannot stall it.
// Reset clears the sequence, the open-frame state and all counters; RAM
//   contents are not cleared and only data from written slots reaches a result.
module frame_capture_ring_core #(
  parameter int RING_SLOTS = 16,
  parameter int SLOT_BYTES = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  frc_pkg::frc_in_t   item_i,
  output logic               done_o,
  output frc_pkg::frc_out_t  result_o
);

  import frc_pkg::*;

  localparam int SW     = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int DW     = $clog2(RING_SLOTS + 1);
  localparam int OFFW   = $clog2(SLOT_BYTES);
  localparam int CAPW   = $clog2(SLOT_BYTES + 1);
  localparam int DEPTH  = RING_SLOTS * SLOT_BYTES;
  localparam int AW     = $clog2(DEPTH);
  localparam int HDR_W  = TIME_W + LEN_W + CAPW + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLAMP = 3'd1;
  localparam logic [2:0] ST_DIST  = 3'd2;
  localparam logic [2:0] ST_SLOT  = 3'd3;
  localparam logic [2:0] ST_ISSUE = 3'd4;
  localparam logic [2:0] ST_DATA  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [SEQ_W-1:0] seq_q, seq_d;
  logic [SW-1:0]    slot_q, slot_d;
  logic [AW-1:0]    base_q, base_d;
  logic             open_q, open_d;
  logic [LEN_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rcv_frm_q, rcv_frm_d, xmt_frm_q, xmt_frm_d;
  logic [TOT_W-1:0] rcv_sum_q, rcv_sum_d, xmt_sum_q, xmt_sum_d;
  logic             done_q;

  logic [SEQ_W-1:0] oldest_q, rseq_q, at_q;
  logic [OFF_W-1:0] roff_q;
  logic             found_q;
  logic [DW-1:0]    dist_q;
  logic [SW-1:0]    rslot_q;
  frc_out_t         result_q, result_d;

  logic             accept, cap_go, rd_go, last_go, store_go;
  logic [LEN_W-1:0] cnt_cur, cnt_new, cap_len;
  logic [CAPW-1:0]  cap_val;
  logic [AW-1:0]    byte_waddr, byte_raddr;
  logic [SEQ_W:0]   span;
  logic [SEQ_W-1:0] oldest;
  logic [DW-1:0]    slot_x;
  logic [SW-1:0]    rslot;
  logic [OFF_W-1:0] roff_use;
  logic [HDR_W-1:0] hdr_wdata, hdr_rdata;
  logic [BYTE_W-1:0] byte_rdata;
  logic [TIME_W-1:0] h_time;
  logic [LEN_W-1:0]  h_len;
  logic [CAPW-1:0]   h_cap;
  logic              h_dir;

  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  assign cap_go  = accept && (item_i.action == ACT_CAPTURE);
  assign rd_go   = accept && (item_i.action == ACT_READ);
  assign last_go = cap_go && item_i.frame_last;

  // capture datapath
  assign cnt_cur    = open_q ? count_q : '0;
  assign cnt_new    = (cnt_cur == LEN_MAX) ? cnt_cur : cnt_cur + LEN_W'(1);
  assign store_go   = cap_go && (cnt_cur < LEN_W'(SLOT_BYTES));
  assign cap_len    = (cnt_new < LEN_W'(SLOT_BYTES)) ? cnt_new : LEN_W'(SLOT_BYTES);
  assign cap_val    = CAPW'(cap_len);
  assign byte_waddr = base_q + AW'(cnt_cur[OFFW-1:0]);
  assign hdr_wdata  = {item_i.timestamp, cnt_new, cap_val, item_i.direction};

  // read datapath
  assign span   = {1'b0, seq_q} + (SEQ_W+1)'(open_q);
  assign oldest = (span >= (SEQ_W+1)'(RING_SLOTS)) ?
                  SEQ_W'(span - (SEQ_W+1)'(RING_SLOTS)) : '0;
  assign slot_x = DW'(slot_q);
  assign rslot  = (slot_x >= dist_q) ? SW'(slot_x - dist_q) :
                  SW'((DW+1)'(slot_x) + (DW+1)'(RING_SLOTS) - (DW+1)'(dist_q));
  assign roff_use   = (32'(roff_q) < SLOT_BYTES) ? roff_q : '0;
  assign byte_raddr = AW'(rslot_q * SLOT_BYTES) + AW'(roff_use);
  assign {h_time, h_len, h_cap, h_dir} = hdr_rdata;

  always_comb begin
    seq_d     = seq_q;
    slot_d    = slot_q;
    base_d    = base_q;
    open_d    = open_q;
    count_d   = count_q;
    rcv_frm_d = rcv_frm_q;
    rcv_sum_d = rcv_sum_q;
    xmt_frm_d = xmt_frm_q;
    xmt_sum_d = xmt_sum_q;
    if (cap_go) begin
      open_d  = !item_i.frame_last;
      count_d = item_i.frame_last ? '0 : cnt_new;
    end
    if (last_go) begin
      seq_d = seq_q + SEQ_W'(1);
      if ((seq_q == '1) || (slot_q == SW'(RING_SLOTS - 1))) begin
        slot_d = '0;
        base_d = '0;
      end else begin
        slot_d = slot_q + SW'(1);
        base_d = base_q + AW'(SLOT_BYTES);
      end
      if (item_i.direction) begin
        xmt_frm_d = xmt_frm_q + CNT_W'(1);
        xmt_sum_d = xmt_sum_q + TOT_W'(cnt_new);
      end else begin
        rcv_frm_d = rcv_frm_q + CNT_W'(1);
        rcv_sum_d = rcv_sum_q + TOT_W'(cnt_new);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  state_d = rd_go ? ST_CLAMP : ST_IDLE;
      ST_CLAMP: state_d = ST_DIST;
      ST_DIST:  state_d = ST_SLOT;
      ST_SLOT:  state_d = ST_ISSUE;
      ST_ISSUE: state_d = ST_DATA;
      ST_DATA:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    result_d = result_q;
    if (cap_go) begin
      result_d                 = '0;
      result_d.receive_frames  = rcv_frm_d;
      result_d.receive_bytes   = rcv_sum_d;
      result_d.transmit_frames = xmt_frm_d;
      result_d.transmit_bytes  = xmt_sum_d;
      result_d.next_sequence   = seq_d;
    end else if (state_q == ST_DATA) begin
      result_d.frame_found     = found_q;
      result_d.frame_seq       = at_q;
      result_d.frame_byte      = (found_q && (32'(roff_q) < 32'(h_cap))) ? byte_rdata : '0;
      result_d.frame_length    = found_q ? h_len : '0;
      result_d.frame_captured  = found_q ? 8'(h_cap) : '0;
      result_d.frame_direction = found_q && h_dir;
      result_d.frame_time      = found_q ? h_time : '0;
      result_d.receive_frames  = rcv_frm_q;
      result_d.receive_bytes   = rcv_sum_q;
      result_d.transmit_frames = xmt_frm_q;
      result_d.transmit_bytes  = xmt_sum_q;
      result_d.next_sequence   = seq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      seq_q     <= '0;
      slot_q    <= '0;
      base_q    <= '0;
      open_q    <= 1'b0;
      count_q   <= '0;
      rcv_frm_q <= '0;
      rcv_sum_q <= '0;
      xmt_frm_q <= '0;
      xmt_sum_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      seq_q     <= seq_d;
      slot_q    <= slot_d;
      base_q    <= base_d;
      open_q    <= open_d;
      count_q   <= count_d;
      rcv_frm_q <= rcv_frm_d;
      rcv_sum_q <= rcv_sum_d;
      xmt_frm_q <= xmt_frm_d;
      xmt_sum_q <= xmt_sum_d;
      done_q    <= cap_go || (state_q == ST_DATA);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_go) begin
      oldest_q <= oldest;
      rseq_q   <= item_i.read_seq;
      roff_q   <= item_i.read_offset;
    end
    if (state_q == ST_CLAMP) begin
      at_q <= (rseq_q < oldest_q) ? oldest_q : rseq_q;
    end
    if (state_q == ST_DIST) begin
      found_q <= (at_q < seq_q);
      dist_q  <= DW'(seq_q - at_q);
    end
    if (state_q == ST_SLOT) begin
      rslot_q <= rslot;
    end
    result_q <= result_d;
  end

  frc_ram #(
    .WIDTH  (BYTE_W),
    .DEPTH  (DEPTH),
    .ADDR_W (AW)
  ) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (store_go),
    .waddr_i (byte_waddr),
    .wdata_i (item_i.data_byte),
    .re_i    (state_q == ST_ISSUE),
    .raddr_i (byte_raddr),
    .rdata_o (byte_rdata)
  );

  frc_ram #(
    .WIDTH  (HDR_W),
    .DEPTH  (RING_SLOTS),
    .ADDR_W (SW)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (last_go),
    .waddr_i (slot_q),
    .wdata_i (hdr_wdata),
    .re_i    (state_q == ST_ISSUE),
    .raddr_i (rslot_q),
    .rdata_o (hdr_rdata)
  );

  assign done_o   = done_q;
  assign result_o = result_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while a read is in flight");

  a_cap_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (item_i.action == ACT_CAPTURE)) |=> done_o)
    else $error("capture beat without result the next cycle");

  a_found_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.frame_found) |->
      (result_o.frame_seq < result_o.next_sequence))
    else $error("found frame at or past the next sequence");

  a_closed_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> (count_q == '0))
    else $error("byte count left over with no open frame");

endmodule

@@ sv/frc_ram.sv @@
// ----------------------------------------------------------------------------
// frc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module frc_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ dv/tb_frame_capture_ring_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_capture_ring_core
// Self-checking bench for the frame capture ring. A queue of capture and read
// beats feeds a clocked driver with random gaps. Each accepted beat updates a
// local copy of the ring and its counters, which gives the expected result.
// A clocked monitor compares every result strobe with the oldest expected
// result. The stimulus covers single-byte and truncated frames, a frame sent
// back to back, reads of open slots, ring wrap and random traffic, with some
// beats held back until all results have come in.
// ----------------------------------------------------------------------------
module tb_frame_capture_ring_core;
  import frc_pkg::*;

  localparam int RING_SLOTS   = 16;
  localparam int SLOT_BYTES   = 128;
  localparam int RANDOM_BEATS = 1600;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 20;

  typedef struct {
    frc_in_t     beat;
    int unsigned gap;
    bit          drain;
  } cmd_t;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  frc_in_t  item   = '0;
  logic     busy;
  logic     done_o;
  frc_out_t result_o;

  cmd_t        cmd_q[$];
  frc_out_t    due_results[$];
  int unsigned beats_sent   = 0;
  int unsigned beats_done   = 0;
  int unsigned idle_done    = 0;
  int unsigned stall_cycles = 0;
  int unsigned error_count  = 0;

  logic [BYTE_W-1:0] ring_data [RING_SLOTS*SLOT_BYTES];
  logic [TIME_W-1:0] hdr_time  [RING_SLOTS];
  logic [LEN_W-1:0]  hdr_len   [RING_SLOTS];
  int unsigned       hdr_cap   [RING_SLOTS];
  logic              hdr_dir   [RING_SLOTS];
  logic [SEQ_W-1:0]  seq_ctr    = '0;
  int unsigned       open_len   = 0;
  logic              open_frame = 1'b0;
  logic [CNT_W-1:0]  rcv_frm    = '0;
  logic [TOT_W-1:0]  rcv_sum    = '0;
  logic [CNT_W-1:0]  xmt_frm    = '0;
  logic [TOT_W-1:0]  xmt_sum    = '0;

  logic [SEQ_W-1:0] frames_made = '0;
  int unsigned      queued_beats = 0;
  bit               no_idle = 1'b0;

  frame_capture_ring_core #(
    .RING_SLOTS(RING_SLOTS),
    .SLOT_BYTES(SLOT_BYTES)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item),
    .done_o  (done_o),
    .result_o(result_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic frc_out_t ring_response(input frc_in_t b);
    frc_out_t        r;
    int unsigned     slot;
    int unsigned     cap;
    logic [SEQ_W:0]  span;
    logic [SEQ_W:0]  oldest;
    logic [SEQ_W:0]  at;
    r = '0;
    if (b.action == ACT_CAPTURE) begin
      slot = int'(seq_ctr % RING_SLOTS);
      if (!open_frame) begin
        open_frame = 1'b1;
        open_len   = 0;
      end
      if (open_len < SLOT_BYTES) ring_data[slot*SLOT_BYTES + open_len] = b.data_byte;
      if (open_len < LEN_MAX) open_len++;
      if (b.frame_last) begin
        cap            = (open_len < SLOT_BYTES) ? open_len : SLOT_BYTES;
        hdr_time[slot] = b.timestamp;
        hdr_len[slot]  = open_len[LEN_W-1:0];
        hdr_cap[slot]  = cap;
        hdr_dir[slot]  = b.direction;
        seq_ctr        = seq_ctr + 1'b1;
        if (b.direction) begin
          xmt_frm = xmt_frm + 1'b1;
          xmt_sum = xmt_sum + open_len;
        end else begin
          rcv_frm = rcv_frm + 1'b1;
          rcv_sum = rcv_sum + open_len;
        end
        open_frame = 1'b0;
        open_len   = 0;
      end
    end else begin
      span   = {1'b0, seq_ctr} + open_frame;
      oldest = (span >= RING_SLOTS) ? span - RING_SLOTS : '0;
      at     = {1'b0, b.read_seq};
      if (at < oldest) at = oldest;
      r.frame_seq = at[SEQ_W-1:0];
      if (at < {1'b0, seq_ctr}) begin
        slot              = int'(at % RING_SLOTS);
        cap               = hdr_cap[slot];
        r.frame_found     = 1'b1;
        if (b.read_offset < cap) r.frame_byte = ring_data[slot*SLOT_BYTES + b.read_offset];
        r.frame_length    = hdr_len[slot];
        r.frame_captured  = cap[7:0];
        r.frame_direction = hdr_dir[slot];
        r.frame_time      = hdr_time[slot];
      end
    end
    r.receive_frames  = rcv_frm;
    r.receive_bytes   = rcv_sum;
    r.transmit_frames = xmt_frm;
    r.transmit_bytes  = xmt_sum;
    r.next_sequence   = seq_ctr;
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (no_idle || pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic add_cmd(input frc_in_t b, input bit drain);
    cmd_t c;
    c.beat  = b;
    c.gap   = gap_len();
    c.drain = drain;
    cmd_q.push_back(c);
    queued_beats++;
  endtask

  task automatic add_capture(input logic dir, input logic [7:0] data, input logic last);
    frc_in_t b;
    logic [63:0] noise;
    noise         = {$urandom, $urandom};
    b.action      = ACT_CAPTURE;
    b.direction   = dir;
    b.data_byte   = data;
    b.frame_last  = last;
    b.timestamp   = $urandom;
    b.read_seq    = noise[SEQ_W-1:0];
    b.read_offset = OFF_W'($urandom_range(0, 127));
    add_cmd(b, 1'b0);
    if (last) frames_made++;
  endtask

  task automatic add_read(input logic [SEQ_W-1:0] seq, input logic [OFF_W-1:0] off,
                          input bit drain);
    frc_in_t b;
    b             = '0;
    b.action      = ACT_READ;
    b.direction   = 1'($urandom_range(0, 1));
    b.data_byte   = BYTE_W'($urandom_range(0, 255));
    b.frame_last  = 1'($urandom_range(0, 1));
    b.timestamp   = $urandom;
    b.read_seq    = seq;
    b.read_offset = off;
    add_cmd(b, drain);
  endtask

  function automatic logic [SEQ_W-1:0] read_target();
    logic [63:0] wide;
    int unsigned back;
    wide = {$urandom, $urandom};
    back = $urandom_range(1, 20);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return wide[SEQ_W-1:0];
      2: return '1;
      3: return frames_made + SEQ_W'($urandom_range(0, 3));
      default: return (frames_made > SEQ_W'(back)) ? frames_made - SEQ_W'(back) : '0;
    endcase
  endfunction

  function automatic logic [OFF_W-1:0] read_spot();
    if ($urandom_range(0, 9) < 7) return OFF_W'($urandom_range(0, 15));
    return OFF_W'($urandom_range(0, 127));
  endfunction

  task automatic add_frame(input int unsigned len, input int unsigned read_pct);
    for (int unsigned i = 0; i < len; i++) begin
      add_capture(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), i == len - 1);
      if (i != len - 1 && $urandom_range(0, 99) < read_pct)
        add_read(read_target(), read_spot(), $urandom_range(0, 49) == 0);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : drive
    bit          took;
    int unsigned sent_now;
    took     = rst_ni && start && !busy;
    sent_now = beats_sent + took;
    if (took) begin
      due_results.push_back(ring_response(item));
      beats_sent <= sent_now;
    end
    if (rst_ni && (took || !start)) begin
      if (cmd_q.size() == 0) begin
        start <= 1'b0;
      end else if (idle_done < cmd_q[0].gap) begin
        start     <= 1'b0;
        idle_done <= idle_done + 1;
      end else if (cmd_q[0].drain && sent_now != beats_done) begin
        start <= 1'b0;
      end else begin
        item      <= cmd_q[0].beat;
        start     <= 1'b1;
        idle_done <= 0;
        void'(cmd_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin : watch
    frc_out_t want;
    if (rst_ni && done_o) begin
      beats_done <= beats_done + 1;
      if (due_results.size() == 0) begin
        $error("result strobe with no command outstanding");
        error_count++;
      end else begin
        want = due_results.pop_front();
        check_field("frame_found", want.frame_found, result_o.frame_found);
        check_field("frame_seq", want.frame_seq, result_o.frame_seq);
        check_field("frame_byte", want.frame_byte, result_o.frame_byte);
        check_field("frame_length", want.frame_length, result_o.frame_length);
        check_field("frame_captured", want.frame_captured, result_o.frame_captured);
        check_field("frame_direction", want.frame_direction, result_o.frame_direction);
        check_field("frame_time", want.frame_time, result_o.frame_time);
        check_field("receive_frames", want.receive_frames, result_o.receive_frames);
        check_field("receive_bytes", want.receive_bytes, result_o.receive_bytes);
        check_field("transmit_frames", want.transmit_frames, result_o.transmit_frames);
        check_field("transmit_bytes", want.transmit_bytes, result_o.transmit_bytes);
        check_field("next_sequence", want.next_sequence, result_o.next_sequence);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned random_base;
    int unsigned pick;
    int unsigned len;

    // empty ring, cursor extremes
    add_read('0, '0, 1'b0);
    add_read('1, 7'd127, 1'b0);
    // one-byte receive frame
    add_capture(1'b0, 8'hFF, 1'b1);
    cmd_q[cmd_q.size()-1].beat.timestamp = '1;
    add_read('0, '0, 1'b0);
    add_read('0, 7'd1, 1'b0);
    // transmit frame; direction of the last byte counts
    add_capture(1'b0, 8'h00, 1'b0);
    add_capture(1'b0, 8'hA5, 1'b0);
    add_capture(1'b1, 8'h5A, 1'b1);
    cmd_q[cmd_q.size()-1].beat.timestamp = '0;
    add_read(48'd1, 7'd2, 1'b0);
    add_read(48'd1, 7'd3, 1'b0);
    // read the slot being filled and past the newest frame
    add_capture(1'b1, 8'h3C, 1'b0);
    add_capture(1'b0, 8'hC3, 1'b0);
    add_read(48'd2, 7'd0, 1'b0);
    add_read(48'd9, 7'd0, 1'b0);
    add_capture(1'b0, 8'h81, 1'b1);
    add_read(48'd2, 7'd1, 1'b1);
    // truncation to the slot size
    add_frame(130, 0);
    add_read(48'd3, 7'd127, 1'b0);
    add_read(48'd3, 7'd0, 1'b0);
    // back-to-back bytes, no gaps
    no_idle = 1'b1;
    add_frame(64, 0);
    no_idle = 1'b0;
    add_read(48'd4, 7'd127, 1'b1);
    add_read('0, 7'd5, 1'b0);

    random_base = queued_beats;
    while (queued_beats - random_base < RANDOM_BEATS) begin
      no_idle = ($urandom_range(0, 5) == 0);
      pick    = $urandom_range(0, 99);
      if (pick < 60) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) len = $urandom_range(1, 8);
        else if (pick < 85) len = $urandom_range(9, 40);
        else if (pick < 97) len = $urandom_range(41, 127);
        else len = $urandom_range(128, 160);
        add_frame(len, 10);
      end else begin
        repeat ($urandom_range(1, 4))
          add_read(read_target(), read_spot(), $urandom_range(0, 49) == 0);
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (cmd_q.size() != 0 || start || beats_sent != beats_done) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (due_results.size() != 0) begin
      $error("%0d expected results never arrived", due_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
